// File: hw/rtl/albsm_pkg.sv
// Shared types and constants for the byte-strobe memory core.
`default_nettype none

package albsm_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int LANES     = 4;
  localparam int ROWS      = MEM_BYTES / LANES;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int OFF_W     = $clog2(MEM_BYTES);
  localparam int LANE_W    = $clog2(LANES);
  localparam int ADDR_W    = 32;
  localparam int DATA_W    = 32;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  typedef enum logic {
    RESP_OKAY   = 1'b0,
    RESP_SLVERR = 1'b1
  } resp_e;

  // Per-bank view of one access
  typedef struct packed {
    logic                          ok;
    logic [LANE_W-1:0]             rot;
    logic [LANES-1:0][ROW_W-1:0]   row;
    logic [LANES-1:0]              ben;
    logic [LANES-1:0][7:0]         bdata;
  } acc_dec_t;

endpackage

`default_nettype wire

// File: hw/rtl/albsm_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none

module albsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/albsm_lane_map.sv
// Window check and byte-lane to bank mapping for one access.
`default_nettype none

module albsm_lane_map (
  input  wire logic [albsm_pkg::ADDR_W-1:0] address_i,
  input  wire logic [albsm_pkg::ADDR_W-1:0] base_i,
  input  wire logic [albsm_pkg::DATA_W-1:0] wdata_i,
  input  wire logic [albsm_pkg::LANES-1:0]  strobe_i,
  output albsm_pkg::acc_dec_t               dec_o
);
  import albsm_pkg::*;

  logic [ADDR_W:0]   diff;
  logic [OFF_W-1:0]  off;
  logic [LANE_W-1:0] rot;

  // Borrow out of the 33-bit subtract means address below base
  assign diff = {1'b0, address_i} - {1'b0, base_i};
  assign off  = diff[OFF_W-1:0];
  assign rot  = off[LANE_W-1:0];

  always_comb begin
    logic [LANE_W-1:0] ln;
    dec_o     = '0;
    dec_o.ok  = !diff[ADDR_W] && (diff[ADDR_W-1:0] <= ADDR_W'(MEM_BYTES - LANES));
    dec_o.rot = rot;
    for (int b = 0; b < LANES; b++) begin
      // bank b carries lane (b - rot) mod 4; banks below rot sit on the next row
      ln             = LANE_W'(b) - rot;
      dec_o.row[b]   = off[OFF_W-1:LANE_W] + ROW_W'(LANE_W'(b) < rot);
      dec_o.ben[b]   = strobe_i[ln];
      dec_o.bdata[b] = wdata_i[8*ln +: 8];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/axi_lite_byte_strobe_memory_core.sv
// Top level of the byte-strobe memory core: handshake, clearing pass and byte banks.
`default_nettype none

// 32-bit byte-addressed memory slave. One transfer on the slave stream is one
// complete access: a read, or a write with data and byte strobes. An access is
// valid when address..address+3 all lie in [base, base + MEM_BYTES). Valid
// writes store the strobed lanes little-endian and answer okay; invalid writes
// change nothing and answer slave error. Reads return the little-endian word
// (zero when invalid) and always answer okay. Exactly one result transfer is
// produced per access, in the cycle after acceptance. Storage is four byte-wide
// banks of MEM_BYTES/4 rows, so an unaligned word touches each bank once and
// any access completes in a single pass: sustained rate is one access per
// clock while the result side keeps taking transfers. After reset the banks
// are zeroed one row per cycle, which holds s_axis_tready low until every row
// is cleared; base address writes are taken throughout. The base register may
// only be written while the core is idle.
module axi_lite_byte_strobe_memory_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: base address of the window
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  // access stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // address[31:0], write_word[63:32],
                                          // byte_strobe[67:64], zero pad
  input  wire logic        s_axis_tuser,  // opcode
  // response stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // response[0], rd_data[32:1], zero pad
  output logic             m_axis_tuser   // was_write
);
  import albsm_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [ROW_W-1:0]  clr_row_q, clr_row_d;
  logic [ADDR_W-1:0] base_q;

  logic              out_valid_q, out_valid_d;
  logic              out_write_q;
  logic              out_ok_q;
  logic [LANE_W-1:0] out_rot_q;

  logic [ADDR_W-1:0] in_address;
  logic [DATA_W-1:0] in_wdata;
  logic [LANES-1:0]  in_strobe;
  opcode_e           in_op;
  logic              accept;
  logic              out_take;
  acc_dec_t          dec;

  logic [LANES-1:0]  bank_we;
  logic [LANES-1:0]  bank_re;
  logic [ROW_W-1:0]  bank_addr  [LANES];
  logic [7:0]        bank_wdata [LANES];
  logic [7:0]        bank_rdata [LANES];
  logic [DATA_W-1:0] rd_word;

  assign in_address = s_axis_tdata[31:0];
  assign in_wdata   = s_axis_tdata[63:32];
  assign in_strobe  = s_axis_tdata[67:64];
  assign in_op      = opcode_e'(s_axis_tuser);

  // Once clearing is done, a new access enters whenever the result register is free or draining
  assign out_take      = out_valid_q && m_axis_tready;
  assign s_axis_tready = (state_q == ST_RUN) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  albsm_lane_map u_lane_map (
    .address_i (in_address),
    .base_i    (base_q),
    .wdata_i   (in_wdata),
    .strobe_i  (in_strobe),
    .dec_o     (dec)
  );

  // Bank port control: clearing pass writes zeros across all banks, otherwise the decoded access drives them
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      if (state_q == ST_CLEAR) begin
        bank_we[b]    = 1'b1;
        bank_re[b]    = 1'b0;
        bank_addr[b]  = clr_row_q;
        bank_wdata[b] = '0;
      end else begin
        bank_we[b]    = accept && (in_op == OP_WRITE) && dec.ok && dec.ben[b];
        bank_re[b]    = accept && (in_op == OP_READ);
        bank_addr[b]  = dec.row[b];
        bank_wdata[b] = dec.bdata[b];
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_bank
    albsm_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .re_i    (bank_re[g]),
      .addr_i  (bank_addr[g]),
      .wdata_i (bank_wdata[g]),
      .rdata_o (bank_rdata[g])
    );
  end

  // Undo the bank rotation of an unaligned read
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rd_word[8*i +: 8] = bank_rdata[LANE_W'(i) + out_rot_q];
    end
  end

  // Clearing sequencer
  always_comb begin
    state_d   = state_q;
    clr_row_d = clr_row_q;
    case (state_q)
      ST_CLEAR: begin
        clr_row_d = clr_row_q + ROW_W'(1);
        if (clr_row_q == ROW_W'(ROWS - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d   = ST_CLEAR;
        clr_row_d = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_row_q   <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_row_q   <= clr_row_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload, held until the transfer completes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_write_q <= (in_op == OP_WRITE);
      out_ok_q    <= dec.ok;
      out_rot_q   <= dec.rot;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_write_q;
  assign m_axis_tdata  = {7'b0,
                          (out_write_q || !out_ok_q) ? {DATA_W{1'b0}} : rd_word,
                          (out_write_q && !out_ok_q) ? RESP_SLVERR : RESP_OKAY};

endmodule

`default_nettype wire
